FILE: rtl/tdpt_pkg.sv
package tdpt_pkg;

   localparam int NUMBER_BITS    = 32;
   localparam int SMALLEST_PRIME = 2;

   typedef struct packed {
      logic load;
      logic div_start;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic below_two;
      logic square_over;
      logic div_done;
      logic rem_zero;
   } status_type;

endpackage

FILE: rtl/tdpt_datapath.sv
module tdpt_datapath #(
   parameter int NUMBER_BITS = tdpt_pkg::NUMBER_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [NUMBER_BITS-1:0]        req_candidate,
   input  tdpt_pkg::cmd_type             cmd,
   output tdpt_pkg::status_type          status
);

   // divisor never passes 2^ceil((n-1)/2), one spare bit
   localparam int DW    = (NUMBER_BITS + 1) / 2 + 1;
   localparam int SQ_W  = 2 * DW;
   localparam int CNT_W = $clog2(NUMBER_BITS + 1);

   logic [NUMBER_BITS-1:0] value_ff, value_in;
   logic [NUMBER_BITS-1:0] dividend_ff, dividend_in;
   logic [DW-1:0]          divisor_ff, divisor_in;
   logic [SQ_W-1:0]        square_ff, square_in;
   logic [DW-1:0]          rem_ff, rem_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [DW:0]            trial;

   assign trial = {rem_ff, dividend_ff[NUMBER_BITS-1]};

   always_comb begin
      value_in    = value_ff;
      dividend_in = dividend_ff;
      divisor_in  = divisor_ff;
      square_in   = square_ff;
      rem_in      = rem_ff;
      count_in    = count_ff;
      if (cmd.load) begin
         value_in   = req_candidate;
         divisor_in = DW'(tdpt_pkg::SMALLEST_PRIME);
         square_in  = SQ_W'(tdpt_pkg::SMALLEST_PRIME * tdpt_pkg::SMALLEST_PRIME);
      end
      if (cmd.advance) begin
         // (d+1)^2 = d^2 + 2d + 1
         square_in  = square_ff + SQ_W'({divisor_ff, 1'b1});
         divisor_in = divisor_ff + DW'(1);
      end
      if (cmd.div_start) begin
         dividend_in = value_ff;
         rem_in      = '0;
         count_in    = CNT_W'(NUMBER_BITS);
      end else if (count_ff != '0) begin
         // one restoring step per cycle
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in = DW'(trial - {1'b0, divisor_ff});
         end else begin
            rem_in = trial[DW-1:0];
         end
         dividend_in = {dividend_ff[NUMBER_BITS-2:0], 1'b0};
         count_in    = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
      square_ff   <= square_in;
      rem_ff      <= rem_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign status.below_two   = value_ff[NUMBER_BITS-1] ||
                               (value_ff < NUMBER_BITS'(tdpt_pkg::SMALLEST_PRIME));
   assign status.square_over = square_ff > SQ_W'(value_ff);
   assign status.div_done    = (count_ff == '0);
   assign status.rem_zero    = (rem_ff == '0);

endmodule

FILE: rtl/tdpt_controller.sv
module tdpt_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_prime_flag,
   output tdpt_pkg::cmd_type    cmd,
   input  tdpt_pkg::status_type status
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_CHECK  = 2'd1;
   localparam logic [1:0] ST_DIVIDE = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       result_ff, result_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_prime_flag_ff, rsp_prime_flag_in;
   logic       req_accept;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      state_in          = state_ff;
      result_in         = result_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_prime_flag_in = rsp_prime_flag_ff;
      cmd               = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.below_two) begin
               result_in = 1'b0;
               state_in  = ST_FINISH;
            end else if (status.square_over) begin
               result_in = 1'b1;
               state_in  = ST_FINISH;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               if (status.rem_zero) begin
                  result_in = 1'b0;
                  state_in  = ST_FINISH;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_CHECK;
               end
            end
         end
         ST_FINISH: begin
            // wait for the output register to drain
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_prime_flag_in = result_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      result_ff         <= result_in;
      rsp_prime_flag_ff <= rsp_prime_flag_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_prime_flag = rsp_prime_flag_ff;

`ifndef SYNTHESIS
   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_CHECK)
      else $error("accepted request did not start checking");

   a_small_not_prime: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && status.below_two) |=> (state_ff == ST_FINISH && !result_ff))
      else $error("small or negative value not rejected");

   a_factor_not_prime: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && status.div_done && status.rem_zero)
      |=> (state_ff == ST_FINISH && !result_ff))
      else $error("zero remainder not reported as composite");
`endif

endmodule

FILE: rtl/trial_division_prime_test.sv
// the search tries divisors in turn until one divides the value or its square passes it
// a factor ends the search early; a 31-bit prime tries about 46340 divisors
// each divisor costs a check step, a bit-serial remainder pass over NUMBER_BITS bits and a decision
// one request at a time; the next is taken once the result sits in the output register
// reset (synchronous, active high) clears the controller state, the divider count and the output valid
module trial_division_prime_test #(
   parameter int NUMBER_BITS = tdpt_pkg::NUMBER_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [NUMBER_BITS-1:0] req_candidate,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_prime_flag
);

   tdpt_pkg::cmd_type    cmd;
   tdpt_pkg::status_type status;

   tdpt_controller u_controller (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_prime_flag (rsp_prime_flag),
      .cmd            (cmd),
      .status         (status)
   );

   tdpt_datapath #(
      .NUMBER_BITS (NUMBER_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_candidate (req_candidate),
      .cmd           (cmd),
      .status        (status)
   );

endmodule

FILE: tb/prime_flag_checker.sv
`timescale 1ns / 1ps

module prime_flag_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [tdpt_pkg::NUMBER_BITS-1:0] req_candidate,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic                             rsp_prime_flag,
   output int                               mismatch_count,
   output int                               pending_count
);

   typedef struct {
      logic [tdpt_pkg::NUMBER_BITS-1:0] candidate;
      logic                             prime_flag;
   } verdict_type;

   verdict_type awaited_verdicts[$];

   // divisor squared is formed in 64 bits, so the largest positive value is safe
   function automatic logic expect_prime(input logic [tdpt_pkg::NUMBER_BITS-1:0] candidate);
      longint unsigned value;
      longint unsigned divisor;
      value = 64'(candidate);
      if (candidate[tdpt_pkg::NUMBER_BITS-1])
         return 1'b0;
      if (value < 64'(tdpt_pkg::SMALLEST_PRIME))
         return 1'b0;
      for (divisor = 64'(tdpt_pkg::SMALLEST_PRIME); divisor * divisor <= value;
           divisor++) begin
         if (value % divisor == 0)
            return 1'b0;
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin : watch_channels
      verdict_type oldest;
      verdict_type fresh;
      if (reset) begin
         awaited_verdicts.delete();
      end else begin
         // results first: a request taken on this edge cannot be answered yet
         if (rsp_valid && !rsp_stall) begin
            if (awaited_verdicts.size() == 0) begin
               $display("%0t: result %0b arrived with no request outstanding",
                        $time, rsp_prime_flag);
               mismatch_count++;
            end else begin
               oldest = awaited_verdicts.pop_front();
               if (rsp_prime_flag !== oldest.prime_flag) begin
                  $display("%0t: prime flag for %0d: expected %0b, actual %0b",
                           $time, $signed(oldest.candidate), oldest.prime_flag,
                           rsp_prime_flag);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            fresh.candidate  = req_candidate;
            fresh.prime_flag = expect_prime(req_candidate);
            awaited_verdicts.push_back(fresh);
         end
      end
      pending_count = awaited_verdicts.size();
   end

endmodule

FILE: tb/trial_division_prime_test_tb.sv
`timescale 1ns / 1ps

module trial_division_prime_test_tb;

   localparam int RUN_LIMIT        = 16_000_000;
   localparam int RANDOM_PER_PHASE = 26;
   localparam int LONG_HOLD        = 3000;

   logic                             clock         = 1'b0;
   logic                             reset         = 1'b1;
   logic                             req_valid     = 1'b0;
   logic                             req_stall;
   logic [tdpt_pkg::NUMBER_BITS-1:0] req_candidate = '0;
   logic                             rsp_valid;
   logic                             rsp_stall     = 1'b0;
   logic                             rsp_prime_flag;

   int mismatch_count;
   int pending_count;
   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;
   int hold_orders       = 0;
   int cycle_count       = 0;

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   trial_division_prime_test dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_candidate  (req_candidate),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_prime_flag (rsp_prime_flag)
   );

   prime_flag_checker flag_monitor (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_candidate  (req_candidate),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_prime_flag (rsp_prime_flag),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin : watchdog
      wait (cycle_count >= RUN_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   // a long hold-off counts down here, otherwise random stalls
   initial begin : result_receiver
      int stall_hold;
      int orders_seen;
      stall_hold  = 0;
      orders_seen = 0;
      forever begin
         @(posedge clock);
         if (hold_orders != orders_seen) begin
            orders_seen = hold_orders;
            stall_hold  = LONG_HOLD;
         end
         if (stall_hold > 0) begin
            stall_hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
         end
      end
   end

   // mostly values whose answer comes quickly; full 31-bit primes would take ages
   function automatic logic [tdpt_pkg::NUMBER_BITS-1:0] pick_candidate();
      int unsigned kind;
      int unsigned factor;
      logic [tdpt_pkg::NUMBER_BITS-1:0] value;
      kind = $urandom_range(99);
      if (kind < 30) begin
         value = $urandom_range(5000);
      end else if (kind < 50) begin
         value = {1'b1, 31'($urandom)};
      end else if (kind < 75) begin
         // large multiple of a small factor, reaches the upper bits cheaply
         factor = $urandom_range(2, 13);
         value  = factor * $urandom_range(32'h7FFF_FFFF / factor);
      end else if (kind < 90) begin
         value = $urandom_range(1 << 18);
      end else begin
         // divisor squared lands exactly on the value
         factor = $urandom_range(2, 1000);
         value  = factor * factor;
      end
      return value;
   endfunction

   task automatic send_request(input logic [tdpt_pkg::NUMBER_BITS-1:0] candidate);
      bit taken;
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_candidate <= candidate;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      wait (pending_count == 0);
      @(posedge clock);
   endtask

   initial begin : stimulus
      logic [tdpt_pkg::NUMBER_BITS-1:0] directed_values[$];
      int phase;
      directed_values = '{
         32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd9, 32'd25, 32'd97, 32'd121,
         32'd7919, 32'd65537, 32'd1000003,
         32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'hAAAA_AAAA,
         32'h5555_5555, 32'h4000_0000, 32'h7FFF_FFFE, 32'h7FFF_FFFD,
         32'd2147395600, 32'h7FFF_FFFF
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct   = 17;
      receiver_idle_pct = 72;
      foreach (directed_values[i])
         send_request(directed_values[i]);
      drain_results();

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct   = 17;
               receiver_idle_pct = 72;
            end
            1: begin
               sender_idle_pct   = 72;
               receiver_idle_pct = 17;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
               // receiver holds off while quick requests keep coming
               hold_orders++;
               repeat (6) send_request($urandom_range(200));
            end
         endcase
         repeat (RANDOM_PER_PHASE) send_request(pick_candidate());
         drain_results();
      end

      repeat (100) @(posedge clock);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

FILE: files.f
rtl/tdpt_pkg.sv
rtl/tdpt_datapath.sv
rtl/tdpt_controller.sv
rtl/trial_division_prime_test.sv
tb/prime_flag_checker.sv
tb/trial_division_prime_test_tb.sv
